/* sv/bpcm_pkg.sv */
// package for the buffer pool clock manager: codes, widths and the result record
`timescale 1ns / 1ps
package bpcm_pkg;
   localparam int FRAMES_DEFAULT = 16;
   localparam int PAGE_W = 31;
   localparam int PIN_W = 8;

   typedef enum logic [2:0] {
      ACT_PIN = 3'd0, ACT_UNPIN = 3'd1, ACT_FREE = 3'd2,
      ACT_FLUSH = 3'd3, ACT_FLUSH_ALL = 3'd4, ACT_COUNT = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_NOT_IN_POOL = 3'd1, ST_POOL_FULL = 3'd2,
      ST_NOT_PINNED = 3'd3, ST_STILL_PINNED = 3'd4, ST_FLUSH_NOT_FOUND = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      MARK_AVAIL = 2'd0, MARK_REF = 2'd1, MARK_PIN = 2'd2
   } mark_type;

   typedef struct packed {
      status_type        status;
      logic [5:0]        frame_index;
      logic              write_request;
      logic [PAGE_W-1:0] wb_page;
      logic              read_request;
      logic              dealloc_request;
      logic [6:0]        unpinned_count;
      logic              last;
   } result_type;
endpackage

/* sv/buffer_pool_clock_manager.sv */
// top level of the buffer pool clock manager: frame table in memory and sequencer
//
//  channel  direction  ports                     payload
//  req      in         req_tvalid/tready/tdata   action, page_id, start_empty
//  rsp      out        rsp_tvalid/tready/tdata   status .. unpinned_count
//                      rsp_tlast                 last
//
// each request walks the frame memory one entry per cycle: a lookup pass over
// all frames, then for a pin miss a clock scan of one frame per cycle, up to
// 2*FRAMES+1 steps, then the write back of the victim and the result.
// flush all emits one result per valid frame, or a single one if none is valid,
// and its pass stalls on rsp_tready while a result waits.
// synchronous active-high reset clears the valid bits, pin counts and marks
// (those are flip-flop arrays) and puts the hand on the last frame; page ids
// live in a memory that needs no clearing.
// rsp holds a registered result; req is accepted only when idle.
`timescale 1ns / 1ps
module buffer_pool_clock_manager #(
   parameter int FRAMES = bpcm_pkg::FRAMES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action [2:0], page_id [33:3], start_empty [34], zero [39:35]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status [2:0], frame_index [8:3], write_request [9], wb_page [40:10],
   // read_request [41], dealloc_request [42], unpinned_count [49:43], zero [55:50]
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast
);
   localparam int FW = $clog2(FRAMES);
   localparam int PW = bpcm_pkg::PAGE_W;
   localparam int SW = $clog2(2*FRAMES+2);

   typedef enum logic [2:0] {
      S_IDLE, S_LOOK, S_SCAN, S_EXEC, S_FALL, S_OUT
   } state_type;

   // frame page memory, one synchronous read port
   logic [PW-1:0] page_mem [FRAMES];
   logic [PW-1:0] rd_data_ff;
   logic [FW-1:0] rd_addr;
   logic          wr_en;
   logic [FW-1:0] wr_addr;
   logic [PW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= page_mem[rd_addr];
   end

   logic [FRAMES-1:0]          valid_ff;
   logic [bpcm_pkg::PIN_W-1:0] pin_ff [FRAMES];
   bpcm_pkg::mark_type         mark_ff [FRAMES];
   logic [FW-1:0]              hand_ff;

   state_type           state_ff;
   bpcm_pkg::action_type act_ff;
   logic [PW-1:0]       page_ff;
   logic                empty_ff;
   logic [FW:0]         idx_ff;      // address issued
   logic [FW-1:0]       cmp_ff;      // frame whose page is in rd_data_ff
   logic                cmp_v_ff;
   logic                hit_ff;
   logic [FW-1:0]       hit_idx_ff;
   logic [SW-1:0]       steps_ff;
   logic                any_ff;
   logic [6:0]          cnt_ff;
   bpcm_pkg::result_type res_ff;
   logic                rsp_v_ff;

   assign req_tready = (state_ff == S_IDLE) && !rsp_v_ff;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tlast  = res_ff.last;
   assign rsp_tdata  = {6'd0, res_ff.unpinned_count, res_ff.dealloc_request,
                        res_ff.read_request, res_ff.wb_page, res_ff.write_request,
                        res_ff.frame_index, res_ff.status};

   logic [FW-1:0] hand_nx;
   assign hand_nx = (hand_ff == FW'(FRAMES-1)) ? '0 : hand_ff + 1'b1;

   always_comb begin
      rd_addr = idx_ff[FW-1:0];
      // keep the flushed frame's page on the read port while its result waits
      if (state_ff == S_LOOK && act_ff == bpcm_pkg::ACT_FLUSH_ALL && cmp_v_ff
          && valid_ff[cmp_ff]) rd_addr = cmp_ff;
      if (state_ff == S_EXEC || state_ff == S_SCAN) rd_addr = hand_ff;
      // victim takes the new page
      wr_en = (state_ff == S_FALL);
      wr_addr = hand_ff;
      wr_data = page_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_v_ff <= 1'b0;
         valid_ff <= '0;
         hand_ff  <= FW'(FRAMES-1);
         for (int i = 0; i < FRAMES; i++) begin
            pin_ff[i]  <= '0;
            mark_ff[i] <= bpcm_pkg::MARK_AVAIL;
         end
      end else begin
         if (rsp_v_ff && rsp_tready) rsp_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  act_ff   <= bpcm_pkg::action_type'(req_tdata[2:0]);
                  page_ff  <= req_tdata[33:3];
                  empty_ff <= req_tdata[34];
                  idx_ff   <= '0;
                  cmp_v_ff <= 1'b0;
                  hit_ff   <= 1'b0;
                  any_ff   <= 1'b0;
                  cnt_ff   <= '0;
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               // lookup pass; flush all also emits here
               if (act_ff == bpcm_pkg::ACT_FLUSH_ALL && cmp_v_ff && valid_ff[cmp_ff]) begin
                  if (!rsp_v_ff || rsp_tready) begin
                     res_ff <= '{status: (pin_ff[cmp_ff] != 0) ? bpcm_pkg::ST_STILL_PINNED
                                         : bpcm_pkg::ST_OK,
                                 frame_index: 6'(cmp_ff), write_request: 1'b1,
                                 wb_page: rd_data_ff, read_request: 1'b0,
                                 dealloc_request: 1'b0, unpinned_count: '0,
                                 last: (valid_ff >> (int'(cmp_ff)+1)) == '0};
                     rsp_v_ff <= 1'b1;
                     any_ff   <= 1'b1;
                     valid_ff[cmp_ff] <= 1'b0;
                     cmp_v_ff <= 1'b0;
                     idx_ff   <= {1'b0, cmp_ff} + 1'b1;
                  end
               end else begin
                  if (cmp_v_ff) begin
                     if (!hit_ff && valid_ff[cmp_ff] && rd_data_ff == page_ff) begin
                        hit_ff <= 1'b1;
                        hit_idx_ff <= cmp_ff;
                     end
                     if (pin_ff[cmp_ff] == 0) cnt_ff <= cnt_ff + 1'b1;
                  end
                  if (idx_ff == (FW+1)'(FRAMES)) begin
                     cmp_v_ff <= 1'b0;
                     if (cmp_v_ff) state_ff <= S_EXEC;
                  end else begin
                     cmp_ff   <= idx_ff[FW-1:0];
                     cmp_v_ff <= 1'b1;
                     idx_ff   <= idx_ff + 1'b1;
                  end
                  if (idx_ff == (FW+1)'(FRAMES) && !cmp_v_ff) state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (!rsp_v_ff || rsp_tready) begin
                  res_ff <= '{status: bpcm_pkg::ST_OK, frame_index: 6'(hit_idx_ff),
                              write_request: 1'b0, wb_page: '0, read_request: 1'b0,
                              dealloc_request: 1'b0, unpinned_count: '0, last: 1'b1};
                  state_ff <= S_IDLE;
                  rsp_v_ff <= 1'b1;
                  case (act_ff)
                     bpcm_pkg::ACT_PIN: begin
                        if (hit_ff) begin
                           if (pin_ff[hit_idx_ff] != '1)
                              pin_ff[hit_idx_ff] <= pin_ff[hit_idx_ff] + 1'b1;
                           mark_ff[hit_idx_ff] <= bpcm_pkg::MARK_PIN;
                        end else begin
                           rsp_v_ff <= 1'b0;
                           hand_ff  <= hand_nx;
                           steps_ff <= '0;
                           state_ff <= S_SCAN;
                        end
                     end
                     bpcm_pkg::ACT_UNPIN: begin
                        if (!hit_ff) begin
                           res_ff.status <= bpcm_pkg::ST_NOT_IN_POOL;
                           res_ff.frame_index <= '0;
                        end else if (pin_ff[hit_idx_ff] == 0) begin
                           res_ff.status <= bpcm_pkg::ST_NOT_PINNED;
                        end else begin
                           pin_ff[hit_idx_ff] <= pin_ff[hit_idx_ff] - 1'b1;
                           if (pin_ff[hit_idx_ff] == 1)
                              mark_ff[hit_idx_ff] <= bpcm_pkg::MARK_REF;
                        end
                     end
                     bpcm_pkg::ACT_FREE: begin
                        if (!hit_ff) begin
                           res_ff.frame_index <= '0;
                           res_ff.dealloc_request <= 1'b1;
                        end else if (pin_ff[hit_idx_ff] > 1) begin
                           res_ff.status <= bpcm_pkg::ST_STILL_PINNED;
                        end else begin
                           pin_ff[hit_idx_ff]  <= '0;
                           mark_ff[hit_idx_ff] <= bpcm_pkg::MARK_AVAIL;
                           valid_ff[hit_idx_ff] <= 1'b0;
                           res_ff.dealloc_request <= 1'b1;
                        end
                     end
                     bpcm_pkg::ACT_FLUSH: begin
                        if (!hit_ff) begin
                           res_ff.status <= bpcm_pkg::ST_FLUSH_NOT_FOUND;
                           res_ff.frame_index <= '0;
                        end else begin
                           valid_ff[hit_idx_ff] <= 1'b0;
                           res_ff.write_request <= 1'b1;
                           res_ff.wb_page <= page_ff;
                           if (pin_ff[hit_idx_ff] != 0)
                              res_ff.status <= bpcm_pkg::ST_STILL_PINNED;
                        end
                     end
                     bpcm_pkg::ACT_FLUSH_ALL: begin
                        rsp_v_ff <= !any_ff;
                        res_ff.frame_index <= '0;
                     end
                     bpcm_pkg::ACT_COUNT: begin
                        res_ff.frame_index <= '0;
                        res_ff.unpinned_count <= cnt_ff;
                     end
                     default: rsp_v_ff <= 1'b0;
                  endcase
               end
            end
            S_SCAN: begin
               // one frame of the clock per cycle; hand already advanced
               if (mark_ff[hand_ff] == bpcm_pkg::MARK_AVAIL) begin
                  state_ff <= S_FALL;
               end else begin
                  if (mark_ff[hand_ff] == bpcm_pkg::MARK_REF)
                     mark_ff[hand_ff] <= bpcm_pkg::MARK_AVAIL;
                  if (steps_ff == SW'(2*FRAMES)) begin
                     res_ff <= '{status: bpcm_pkg::ST_POOL_FULL, frame_index: '0,
                                 write_request: 1'b0, wb_page: '0, read_request: 1'b0,
                                 dealloc_request: 1'b0, unpinned_count: '0, last: 1'b1};
                     state_ff <= S_OUT;
                  end else begin
                     steps_ff <= steps_ff + 1'b1;
                     hand_ff  <= hand_nx;
                  end
               end
            end
            S_FALL: begin
               // old page of the victim is in rd_data_ff now
               res_ff <= '{status: bpcm_pkg::ST_OK, frame_index: 6'(hand_ff),
                           write_request: valid_ff[hand_ff],
                           wb_page: valid_ff[hand_ff] ? rd_data_ff : '0,
                           read_request: !empty_ff, dealloc_request: 1'b0,
                           unpinned_count: '0, last: 1'b1};
               valid_ff[hand_ff] <= 1'b1;
               pin_ff[hand_ff]   <= 8'd1;
               mark_ff[hand_ff]  <= bpcm_pkg::MARK_PIN;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_v_ff || rsp_tready) begin
                  rsp_v_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   // no new request while a result or a pass is pending
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == S_IDLE && !rsp_v_ff))
      else $error("request taken while busy");
   // a held result keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && rsp_tvalid)
      else $error("result changed while stalled");
   // the clock hand stays inside the pool
   a_hand_range: assert property (@(posedge clock) disable iff (reset)
      int'(hand_ff) < FRAMES)
      else $error("clock hand out of range");
`endif
endmodule
